// ----- src/lld_pkg.sv -----
// lld_pkg: constants, opcode codes and the wavefront token type shared by
// the dynamic-programming cell chain, its top level and its checker.
// No dependencies.
package lld_pkg;

   localparam int MAX_LEN     = 1024;
   localparam int SYM_W       = 8;
   localparam int VAL_W       = 11;
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int CNT_W       = $clog2(MAX_LEN + 2);
   localparam int RSP_LATENCY = MAX_LEN + 2;

   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_STREAM = 1'b1
   } opcode_type;

   // One second-string symbol moving down the chain with the values the next
   // cell needs: the new value of the column to its left and the old one.
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [SYM_W-1:0] symbol;
      logic [VAL_W-1:0] left;
      logic [VAL_W-1:0] diag;
   } tok_type;

endpackage

// ----- src/lcs_length_dp_top.sv -----
// Longest common subsequence length engine built as a systolic chain of
// MAX_LEN cells, one per first-string column. Load words (opcode load) write
// the first string into the cells one symbol each; stream words (opcode
// stream) enter the chain one per cycle and move one cell per cycle, each
// cell updating its column of the DP row as the wavefront passes. A stream
// word marked last raises rsp_valid after passing the entry token register,
// one register per cell and the result register. Stream words are taken at
// one per cycle unless a final one is stalled. A load word waits until every
// stream word in the chain has left it, and a final stream word waits while
// an earlier result is still pending or waiting on the result channel. The
// DP row lives in the cells' flip-flops, which reset clears and row_clear
// clears in all columns together, so there is no clearing pass after reset.
// Depends on lld_pkg and lld_cell.
module lcs_length_dp_top import lld_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_opcode,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_last,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [VAL_W-1:0] rsp_lcs_length,
   output logic             rsp_overflow
);

   // first-string bookkeeping
   logic [LEN_W-1:0] first_len_ff, first_len_in;
   logic             ovf_ff, ovf_in;
   logic             done_ff, done_in;
   // chain occupancy and result tracking
   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_len_ff;
   logic             rsp_ovf_ff;
   tok_type          tok0_ff, tok0_in;

   logic             req_acc, load_acc, stream_acc, rsp_acc, exit_res;
   logic [LEN_W-1:0] len_base;
   logic             sym_wr, row_clear;

   tok_type          chain [MAX_LEN+1];

   // Stall a load while the chain still holds stream words, and a final
   // stream word while the previous result is still owed.
   always_comb begin
      if (req_opcode == OP_LOAD) begin
         req_stall = (inflight_ff != '0);
      end else begin
         req_stall = req_last && pend_ff;
      end
   end

   assign req_acc    = req_valid && !req_stall;
   assign load_acc   = req_acc && (req_opcode == OP_LOAD);
   assign stream_acc = req_acc && (req_opcode == OP_STREAM);
   assign rsp_acc    = rsp_valid_ff && !rsp_stall;
   assign exit_res   = chain[MAX_LEN].valid && chain[MAX_LEN].last;

   // A load after a finished first string starts a new one.
   assign len_base  = done_ff ? '0 : first_len_ff;
   assign sym_wr    = load_acc && (len_base < LEN_W'(MAX_LEN));
   assign row_clear = load_acc && (done_ff || req_last);

   always_comb begin
      first_len_in = first_len_ff;
      ovf_in       = ovf_ff;
      done_in      = done_ff;
      if (load_acc) begin
         if (sym_wr) begin
            first_len_in = len_base + LEN_W'(1);
            ovf_in       = done_ff ? 1'b0 : ovf_ff;
         end else begin
            // drop symbols beyond the cell count and flag it
            first_len_in = len_base;
            ovf_in       = 1'b1;
         end
         done_in = req_last;
      end

      inflight_in = inflight_ff + CNT_W'(stream_acc) - CNT_W'(chain[MAX_LEN].valid);

      pend_in = pend_ff;
      if (stream_acc && req_last) begin
         pend_in = 1'b1;
      end else if (rsp_acc) begin
         pend_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (exit_res) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_acc) begin
         rsp_valid_in = 1'b0;
      end

      // column zero is a constant zero
      tok0_in.valid  = stream_acc;
      tok0_in.last   = req_last;
      tok0_in.symbol = req_symbol;
      tok0_in.left   = '0;
      tok0_in.diag   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff <= '0;
         ovf_ff       <= 1'b0;
         done_ff      <= 1'b0;
         inflight_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tok0_ff      <= '0;
      end else begin
         first_len_ff <= first_len_in;
         ovf_ff       <= ovf_in;
         done_ff      <= done_in;
         inflight_ff  <= inflight_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         tok0_ff      <= tok0_in;
      end
   end

   // Hold the result word; the output is always empty when one arrives.
   always_ff @(posedge clock) begin
      if (exit_res) begin
         rsp_len_ff <= chain[MAX_LEN].left;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign chain[0] = tok0_ff;

   // Cells past the loaded length pass the left value straight through, so
   // the chain end always shows the last loaded column.
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      lld_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .row_clear (row_clear),
         .active    (first_len_ff > LEN_W'(i)),
         .sym_wr    (sym_wr && (len_base == LEN_W'(i))),
         .wr_symbol (req_symbol),
         .prev_tok  (chain[i]),
         .next_tok  (chain[i+1])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lcs_length = rsp_len_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

// ----- src/lld_cell.sv -----
// lld_cell: one column of the DP row. Holds one first-string symbol and the
// row value of its column, and passes the wavefront token on. Uses lld_pkg.
module lld_cell import lld_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             row_clear,
   input  logic             active,
   input  logic             sym_wr,
   input  logic [SYM_W-1:0] wr_symbol,
   input  tok_type          prev_tok,
   output tok_type          next_tok
);

   logic [SYM_W-1:0] sym_ff;
   logic [VAL_W-1:0] row_ff, row_in;
   tok_type          tok_ff, tok_in;
   logic [VAL_W-1:0] diag_inc, best, cell_val;

   always_comb begin
      // saturate so the count never wraps
      diag_inc = (prev_tok.diag == VAL_MAX) ? VAL_MAX : prev_tok.diag + VAL_W'(1);
      best     = (row_ff > prev_tok.left) ? row_ff : prev_tok.left;
      cell_val = (prev_tok.symbol == sym_ff) ? diag_inc : best;

      row_in = row_ff;
      if (row_clear) begin
         row_in = '0;
      end else if (prev_tok.valid && active) begin
         // the final symbol of a string clears the column behind it
         row_in = prev_tok.last ? '0 : cell_val;
      end

      tok_in = prev_tok;
      if (active) begin
         tok_in.left = cell_val;
         tok_in.diag = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         tok_ff <= '0;
      end else begin
         row_ff <= row_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sym_wr) begin
         sym_ff <= wr_symbol;
      end
   end

   assign next_tok = tok_ff;

endmodule

// ----- src/lld_checker.sv -----
// lld_checker: port-level checks on the subsequence length engine, bound to
// lcs_length_dp_top. Uses lld_pkg.
module lld_checker import lld_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             req_opcode,
   input logic [SYM_W-1:0] req_symbol,
   input logic             req_last,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [VAL_W-1:0] rsp_lcs_length,
   input logic             rsp_overflow
);

   logic final_stream_acc;

   assign final_stream_acc = req_valid && !req_stall && (req_opcode == OP_STREAM) && req_last;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_lcs_length) && $stable(rsp_overflow))
      else $error("stalled result word changed");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(final_stream_acc, RSP_LATENCY))
      else $error("result word without a final stream word at chain latency");

   a_one_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !final_stream_acc)
      else $error("final stream word taken while a result waits");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (MAX_LEN <= int'(VAL_MAX)) |-> int'(rsp_lcs_length) <= MAX_LEN)
      else $error("result length exceeds the cell count");

endmodule

bind lcs_length_dp_top lld_checker u_lld_checker (.*);
